// ----- hw/rtl/vha_pkg.sv -----
// types and constants shared by the versioned handle allocator
package vha_pkg;

    localparam int IDX_W    = 8;
    localparam int VER_W    = 16;
    localparam int STATUS_W = 2;

    typedef enum logic
    {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0]
    {
        STATUS_ALLOCATED = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_FREED     = 2'd2
    } status_t;

    typedef struct packed
    {
        cmd_t             command;
        logic [IDX_W-1:0] free_index;
        logic [VER_W-1:0] free_version;
    } vha_in_t;

    typedef struct packed
    {
        status_t          status;
        logic [IDX_W-1:0] handle_index;
        logic [VER_W-1:0] handle_version;
    } vha_out_t;

endpackage

// ----- hw/rtl/vha_free_list.sv -----
// slot table memory, clearing pass and cached head and next-slot entries
module vha_free_list
    import vha_pkg::*;
#(
    parameter int SLOT_COUNT   = 256,
    parameter int VERSION_BITS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  vha_in_t  req,
    output vha_out_t result,
    output logic     busy
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int LW = $clog2(SLOT_COUNT + 1);
    localparam int CW = (LW > IDX_W) ? LW : IDX_W;
    localparam int XW = (VERSION_BITS > VER_W) ? VERSION_BITS : VER_W;
    localparam int SECOND_LINK = (SLOT_COUNT > 2) ? 2 : SLOT_COUNT;

    typedef struct packed
    {
        logic [LW-1:0]           link;
        logic [VERSION_BITS-1:0] ver;
    } entry_t;

    entry_t slot_mem [SLOT_COUNT];
    entry_t rdata_reg;

    logic [LW-1:0]           head_idx_reg, head_idx_next;
    logic [LW-1:0]           head_link_reg, head_link_next;
    logic [VERSION_BITS-1:0] head_ver_reg, head_ver_next;
    entry_t                  n_hold_reg, n_hold_next;
    logic                    n_sel_mem_reg, n_sel_mem_next;
    logic [LW-1:0]           clr_cnt_reg, clr_cnt_next;

    entry_t                  n_cur;
    logic                    empty;
    logic                    do_alloc;
    logic                    do_free;
    logic [CW-1:0]           f_wide;
    logic                    f_in_range;
    logic [LW-1:0]           f_link;
    logic [XW-1:0]           v_wide;
    logic [VERSION_BITS-1:0] v_inc;
    logic                    mem_we;
    logic [IW-1:0]           mem_waddr;
    entry_t                  mem_wdata;
    logic                    mem_re;
    logic [IW-1:0]           mem_raddr;
    logic                    bypass;

    assign busy       = (clr_cnt_reg != LW'(SLOT_COUNT));
    assign n_cur      = n_sel_mem_reg ? rdata_reg : n_hold_reg;
    assign empty      = (head_idx_reg == LW'(SLOT_COUNT));
    assign f_wide     = CW'(req.free_index);
    assign f_in_range = (f_wide < CW'(SLOT_COUNT));
    assign f_link     = LW'(f_wide);
    assign v_wide     = XW'(req.free_version);
    assign v_inc      = VERSION_BITS'(v_wide) + VERSION_BITS'(1);
    assign do_alloc   = fire && (req.command == CMD_ALLOC) && !empty;
    assign do_free    = fire && (req.command == CMD_FREE) && f_in_range;

    // prefetch the slot after the next one while popping
    assign mem_re    = do_alloc;
    assign mem_raddr = n_cur.link[IW-1:0];
    assign bypass    = mem_re && mem_we && (mem_raddr == mem_waddr);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg[IW-1:0];
        mem_wdata = '{link: clr_cnt_reg + LW'(1), ver: '0};
        if (busy)
        begin
            mem_we = 1'b1;
        end
        else if (do_alloc)
        begin
            // a live slot links to itself
            mem_we    = 1'b1;
            mem_waddr = head_idx_reg[IW-1:0];
            mem_wdata = '{link: head_idx_reg, ver: head_ver_reg};
        end
        else if (do_free)
        begin
            mem_we    = 1'b1;
            mem_waddr = f_link[IW-1:0];
            mem_wdata = '{link: head_idx_reg, ver: v_inc};
        end
    end

    always_comb
    begin
        clr_cnt_next   = busy ? clr_cnt_reg + LW'(1) : clr_cnt_reg;
        head_idx_next  = head_idx_reg;
        head_link_next = head_link_reg;
        head_ver_next  = head_ver_reg;
        n_hold_next    = n_cur;
        n_sel_mem_next = 1'b0;
        if (do_alloc)
        begin
            head_idx_next  = head_link_reg;
            head_link_next = n_cur.link;
            head_ver_next  = n_cur.ver;
            if (bypass)
            begin
                n_hold_next = '{link: head_idx_reg, ver: head_ver_reg};
            end
            else
            begin
                n_sel_mem_next = 1'b1;
            end
        end
        else if (do_free)
        begin
            head_idx_next  = f_link;
            head_link_next = head_idx_reg;
            head_ver_next  = v_inc;
            // double free of the head makes it link to itself
            if (f_link == head_idx_reg)
            begin
                n_hold_next = '{link: f_link, ver: v_inc};
            end
            else
            begin
                n_hold_next = '{link: head_link_reg, ver: head_ver_reg};
            end
        end
    end

    always_comb
    begin
        result = '{status: STATUS_FREED, handle_index: '0, handle_version: '0};
        case (req.command)
            CMD_ALLOC:
            begin
                if (empty)
                begin
                    result.status = STATUS_EMPTY;
                end
                else
                begin
                    result.status         = STATUS_ALLOCATED;
                    result.handle_index   = IDX_W'(head_idx_reg);
                    result.handle_version = VER_W'(XW'(head_ver_reg));
                end
            end
            CMD_FREE:
            begin
                result.status = STATUS_FREED;
            end
            default:
            begin
                result.status = STATUS_FREED;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= slot_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            head_idx_reg  <= '0;
            head_link_reg <= LW'(1);
            head_ver_reg  <= '0;
            n_hold_reg    <= '{link: LW'(SECOND_LINK), ver: '0};
            n_sel_mem_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            head_idx_reg  <= head_idx_next;
            head_link_reg <= head_link_next;
            head_ver_reg  <= head_ver_next;
            n_hold_reg    <= n_hold_next;
            n_sel_mem_reg <= n_sel_mem_next;
        end
    end

endmodule

// ----- hw/rtl/versioned_handle_allocator_unit.sv -----
// versioned handle allocator top level: request handshake and result register
// a request transfer's result is registered and shows in the result register in the next cycle
// throughput: one request per cycle while req_ready is high; head slot and next slot sit in
// registers and the table read for an allocate prefetches the slot after them
// reset: after rst_n a clearing pass writes every slot while req_ready is low;
// the free list then holds all slots in order at version zero
module versioned_handle_allocator_unit
    import vha_pkg::*;
#(
    parameter int SLOT_COUNT   = 256,
    parameter int VERSION_BITS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  vha_in_t  req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output vha_out_t rsp
);

    logic     fire;
    logic     busy;
    vha_out_t result;
    logic     rsp_valid_reg, rsp_valid_next;
    vha_out_t rsp_reg, rsp_next;

    assign req_ready = !busy && (!rsp_valid_reg || rsp_ready);
    assign fire      = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    vha_free_list #(
        .SLOT_COUNT   (SLOT_COUNT),
        .VERSION_BITS (VERSION_BITS)
    ) u_free_list (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .req    (req),
        .result (result),
        .busy   (busy)
    );

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (fire)
        begin
            rsp_next       = result;
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ----- hw/rtl/vha_checker.sv -----
// port checker for the versioned handle allocator, bound to the top level
module vha_checker
    import vha_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input vha_in_t  req,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input vha_out_t rsp
);

    // every request transfer shows a result in the next cycle
    a_req_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> rsp_valid)
        else $error("request transfer without result");

    // a fresh result only follows a request transfer
    a_rsp_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !$past(rsp_valid && !rsp_ready))
            |-> $past(req_valid && req_ready))
        else $error("result without request");

    // a free is always answered as freed
    a_free_status: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req.command == CMD_FREE)
            |=> rsp.status == STATUS_FREED)
        else $error("free not answered as freed");

    // only an allocation carries a handle
    a_zero_handle: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != STATUS_ALLOCATED)
            |-> (rsp.handle_index == '0 && rsp.handle_version == '0))
        else $error("handle fields set without allocation");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled result changed");

endmodule

bind versioned_handle_allocator_unit vha_checker u_vha_checker (.*);
